// ----- rtl/bbt_pkg.sv -----
// ============================================================================
// bbt_pkg
// Types and constants shared by the banked breakpoint table.
// ============================================================================
`default_nettype none

package bbt_pkg;

    typedef enum logic [1:0] {
        OP_SET    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_CHECK  = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    localparam logic [17:0] FLAT_SIZE = 18'd65536;
    localparam logic [17:0] BANK_SIZE = 18'd16384;
    localparam logic [15:0] BANK_BASE = 16'h4000;
    localparam logic [15:0] ROM_END   = 16'h8000;
    localparam logic [9:0]  ROM_BANKS_RESET = 10'd512;

    localparam logic STATUS_OK     = 1'b0;
    localparam logic STATUS_REJECT = 1'b1;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] point_id;
        logic        region;
        logic [8:0]  bank;
        logic [15:0] start_offset;
        logic [16:0] span_length;
        logic        enable;
        logic [15:0] program_counter;
        logic [8:0]  low_rom_bank;
        logic [8:0]  high_rom_bank;
        logic        cpu_halted;
        logic        irq_pending;
    } in_item_t;

    typedef struct packed {
        logic        status;
        logic [31:0] hit_id;
    } out_item_t;

    typedef struct packed {
        logic [31:0] id;
        logic        region;
        logic [8:0]  bank;
        logic [15:0] start;
        logic [16:0] length;
        logic        enabled;
    } entry_t;

endpackage

`default_nettype wire

// ----- rtl/banked_breakpoint_table.sv -----
// A set or remove scans every entry before its result; a check scans
// until the first hit or the end of the table. A rejected set, a check
// while halted or with an interrupt pending and an unused code skip the
// scan. One item at a time; the scan of the entry memory, one read per
// cycle, sets the rate. After reset a clearing pass frees every entry
// before the first item is taken.
// ============================================================================
// banked_breakpoint_table
// Range breakpoint table kept in one synchronous memory, scanned in order.
// ============================================================================
`default_nettype none

module banked_breakpoint_table #(
    parameter int TABLE_ENTRIES = 256
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_valid,
    output logic                s_ready,
    input  bbt_pkg::in_item_t   s_item,
    output logic                m_valid,
    input  wire                 m_ready,
    output bbt_pkg::out_item_t  m_item,
    input  wire                 cfg_wr_en,
    input  wire  [9:0]          cfg_wr_data
);
    import bbt_pkg::*;

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(TABLE_ENTRIES);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TABLE_ENTRIES - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_DONE
    } state_t;

    state_t          state_reg, state_next;
    in_item_t        item_reg, item_next;
    out_item_t       res_reg, res_next;
    out_item_t       m_item_reg, m_item_next;
    logic            m_valid_reg, m_valid_next;
    logic [9:0]      rom_banks_reg, rom_banks_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic            cmp_vld_reg, cmp_vld_next;
    logic [IDX_W-1:0] cmp_idx_reg, cmp_idx_next;
    logic            match_found_reg, match_found_next;
    logic [IDX_W-1:0] match_slot_reg, match_slot_next;
    logic            free_found_reg, free_found_next;
    logic [IDX_W-1:0] free_slot_reg, free_slot_next;

    entry_t          mem [0:TABLE_ENTRIES-1];
    entry_t          rd_data_reg;
    logic            rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic            wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t          wr_data;

    logic [17:0]     set_sum;
    logic            set_ok;
    logic [8:0]      cur_bank;
    logic [15:0]     where;
    logic [16:0]     diff;
    logic            bank_ok;
    logic            hit;
    logic            id_match;

    always_comb begin
        set_sum = {2'b00, s_item.start_offset} + {1'b0, s_item.span_length};
        set_ok  = (s_item.point_id != 32'd0) && (s_item.span_length != 17'd0);
        if (s_item.region) begin
            set_ok = set_ok && ({1'b0, s_item.bank} < rom_banks_reg)
                     && ({2'b00, s_item.start_offset} < BANK_SIZE)
                     && (set_sum <= BANK_SIZE);
        end else begin
            set_ok = set_ok && (s_item.bank == 9'd0) && (set_sum <= FLAT_SIZE);
        end
    end

    always_comb begin
        cur_bank = (item_reg.program_counter < BANK_BASE) ? item_reg.low_rom_bank
                                                          : item_reg.high_rom_bank;
        where    = rd_data_reg.region ? {2'b00, item_reg.program_counter[13:0]}
                                      : item_reg.program_counter;
        diff     = {1'b0, where} - {1'b0, rd_data_reg.start};
        bank_ok  = !rd_data_reg.region
                   || ((item_reg.program_counter < ROM_END) && (rd_data_reg.bank == cur_bank));
        hit      = (rd_data_reg.id != 32'd0) && rd_data_reg.enabled && bank_ok
                   && (where >= rd_data_reg.start) && (diff < rd_data_reg.length);
        id_match = (rd_data_reg.id == item_reg.point_id);
    end

    always_comb begin
        state_next       = state_reg;
        item_next        = item_reg;
        res_next         = res_reg;
        m_item_next      = m_item_reg;
        m_valid_next     = m_valid_reg;
        rom_banks_next   = cfg_wr_en ? cfg_wr_data : rom_banks_reg;
        idx_next         = idx_reg;
        cmp_vld_next     = 1'b0;
        cmp_idx_next     = cmp_idx_reg;
        match_found_next = match_found_reg;
        match_slot_next  = match_slot_reg;
        free_found_next  = free_found_reg;
        free_slot_next   = free_slot_reg;
        rd_en            = 1'b0;
        rd_addr          = idx_reg[IDX_W-1:0];
        wr_en            = 1'b0;
        wr_addr          = cmp_idx_reg;
        wr_data          = rd_data_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = idx_reg[IDX_W-1:0];
                wr_data = '0;
                if (idx_reg == CNT_LAST) begin
                    idx_next   = '0;
                    state_next = S_IDLE;
                end else begin
                    idx_next = idx_reg + CNT_W'(1);
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    item_next        = s_item;
                    idx_next         = '0;
                    match_found_next = 1'b0;
                    free_found_next  = 1'b0;
                    res_next         = '{status: STATUS_OK, hit_id: 32'd0};
                    case (op_t'(s_item.operation))
                        OP_SET: begin
                            if (set_ok) begin
                                state_next = S_SCAN;
                            end else begin
                                res_next.status = STATUS_REJECT;
                                state_next      = S_DONE;
                            end
                        end
                        OP_REMOVE: begin
                            state_next = S_SCAN;
                        end
                        OP_CHECK: begin
                            state_next = (s_item.cpu_halted || s_item.irq_pending)
                                         ? S_DONE : S_SCAN;
                        end
                        default: begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (idx_reg != CNT_END) begin
                    rd_en        = 1'b1;
                    idx_next     = idx_reg + CNT_W'(1);
                    cmp_vld_next = 1'b1;
                    cmp_idx_next = idx_reg[IDX_W-1:0];
                end
                if (cmp_vld_reg) begin
                    case (op_t'(item_reg.operation))
                        OP_SET: begin
                            if (id_match && !match_found_reg) begin
                                match_found_next = 1'b1;
                                match_slot_next  = cmp_idx_reg;
                            end
                            if ((rd_data_reg.id == 32'd0) && !free_found_reg) begin
                                free_found_next = 1'b1;
                                free_slot_next  = cmp_idx_reg;
                            end
                        end
                        OP_REMOVE: begin
                            if (id_match) begin
                                wr_en      = 1'b1;
                                wr_data.id = 32'd0;
                            end
                        end
                        OP_CHECK: begin
                            if (hit) begin
                                res_next.hit_id = rd_data_reg.id;
                                cmp_vld_next    = 1'b0;
                                state_next      = S_DONE;
                            end
                        end
                        default: begin
                        end
                    endcase
                end else if (idx_reg == CNT_END) begin
                    state_next = S_DONE;
                    if (op_t'(item_reg.operation) == OP_SET) begin
                        if (match_found_reg || free_found_reg) begin
                            wr_en   = 1'b1;
                            wr_addr = match_found_reg ? match_slot_reg : free_slot_reg;
                            wr_data = '{id:      item_reg.point_id,
                                        region:  item_reg.region,
                                        bank:    item_reg.bank,
                                        start:   item_reg.start_offset,
                                        length:  item_reg.span_length,
                                        enabled: item_reg.enable};
                        end else begin
                            res_next.status = STATUS_REJECT;
                        end
                    end
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_item_next  = res_reg;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_CLEAR;
            m_valid_reg     <= 1'b0;
            rom_banks_reg   <= ROM_BANKS_RESET;
            idx_reg         <= '0;
            cmp_vld_reg     <= 1'b0;
            match_found_reg <= 1'b0;
            free_found_reg  <= 1'b0;
        end else begin
            state_reg       <= state_next;
            m_valid_reg     <= m_valid_next;
            rom_banks_reg   <= rom_banks_next;
            idx_reg         <= idx_next;
            cmp_vld_reg     <= cmp_vld_next;
            match_found_reg <= match_found_next;
            free_found_reg  <= free_found_next;
        end
        item_reg       <= item_next;
        res_reg        <= res_next;
        m_item_reg     <= m_item_next;
        cmp_idx_reg    <= cmp_idx_next;
        match_slot_reg <= match_slot_next;
        free_slot_reg  <= free_slot_next;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    a_wr_in_scan_or_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> (state_reg == S_CLEAR || state_reg == S_SCAN))
        else $error("entry write outside clear or scan");

    a_read_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_en |-> (idx_reg < CNT_END))
        else $error("entry read beyond table");

    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result raised outside done state");

    a_reject_no_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(m_item_reg.status && (m_item_reg.hit_id != 32'd0)))
        else $error("rejected item carries a hit id");

    a_cmp_after_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        cmp_vld_reg |-> $past(state_reg == S_SCAN))
        else $error("compare stage valid without a scan");

endmodule

`default_nettype wire

// ----- tb/tb_banked_breakpoint_table.sv -----
// ============================================================================
// tb_banked_breakpoint_table
// Self-checking bench for the banked breakpoint table. Set, remove and check
// items run through the block and through a bench-side copy of the table;
// every result is compared field by field, in order. Runs cover ROM bank
// counts at and beyond their limits, a full table, and handshake idling.
// ============================================================================
`default_nettype none

module tb_banked_breakpoint_table;
    timeunit 1ns;
    timeprecision 1ps;

    import bbt_pkg::*;

    localparam int TABLE_ENTRIES  = 256;
    localparam int WATCHDOG_LIMIT = 20 * TABLE_ENTRIES;
    localparam int SETTLE_CYCLES  = TABLE_ENTRIES + 8;
    localparam int ID_POOL        = 48;
    localparam int MAX_REPORTS    = 10;

    logic       aclk        = 1'b0;
    logic       aresetn     = 1'b0;
    logic       s_valid     = 1'b0;
    logic       s_ready;
    in_item_t   s_item      = '0;
    logic       m_valid;
    logic       m_ready     = 1'b0;
    out_item_t  m_item;
    logic       cfg_wr_en   = 1'b0;
    logic [9:0] cfg_wr_data = '0;

    entry_t     bp_table [TABLE_ENTRIES];
    logic [9:0] rom_bank_count;
    out_item_t  expected_results [$];
    int         mismatch_count     = 0;
    int         quiet_cycles       = 0;
    int         sender_idle_pct    = 0;
    int         receiver_stall_pct = 0;

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    banked_breakpoint_table #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) i_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_item     (m_item),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    function automatic out_item_t predict_result(in_item_t it);
        out_item_t   res;
        int          slot;
        bit          matched;
        int          span_limit;
        logic [8:0]  cur_bank;
        int          where;
        bit          covered;
        res = '{status: STATUS_OK, hit_id: '0};
        case (it.operation)
            OP_SET: begin
                span_limit = it.region ? int'(BANK_SIZE) : int'(FLAT_SIZE);
                if (it.point_id == '0 || it.span_length == '0
                        || (!it.region && it.bank != '0)
                        || (it.region && {1'b0, it.bank} >= rom_bank_count)
                        || int'(it.start_offset) >= span_limit
                        || int'(it.span_length) > span_limit - int'(it.start_offset)) begin
                    res.status = STATUS_REJECT;
                end else begin
                    slot = -1;
                    matched = 1'b0;
                    for (int i = 0; i < TABLE_ENTRIES; i++) begin
                        if (!matched && bp_table[i].id == it.point_id) begin
                            slot = i;
                            matched = 1'b1;
                        end else if (!matched && slot < 0 && bp_table[i].id == '0) begin
                            slot = i;
                        end
                    end
                    if (slot < 0) begin
                        res.status = STATUS_REJECT;
                    end else begin
                        bp_table[slot] = '{id: it.point_id, region: it.region, bank: it.bank,
                                           start: it.start_offset, length: it.span_length,
                                           enabled: it.enable};
                    end
                end
            end
            OP_REMOVE: begin
                foreach (bp_table[i]) begin
                    if (bp_table[i].id == it.point_id) bp_table[i].id = '0;
                end
            end
            OP_CHECK: begin
                if (!it.cpu_halted && !it.irq_pending) begin
                    cur_bank = (it.program_counter < BANK_SIZE) ? it.low_rom_bank
                                                                : it.high_rom_bank;
                    for (int i = 0; i < TABLE_ENTRIES; i++) begin
                        if (res.hit_id == '0 && bp_table[i].id != '0 && bp_table[i].enabled) begin
                            if (bp_table[i].region) begin
                                covered = it.program_counter < ROM_END
                                          && bp_table[i].bank == cur_bank;
                                where = int'(it.program_counter) % int'(BANK_SIZE);
                            end else begin
                                covered = 1'b1;
                                where = int'(it.program_counter);
                            end
                            if (covered && where >= int'(bp_table[i].start)
                                    && where - int'(bp_table[i].start) < int'(bp_table[i].length)) begin
                                res.hit_id = bp_table[i].id;
                            end
                        end
                    end
                end
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    always @(posedge aclk) begin
        out_item_t want;
        if (!aresetn) begin
            rom_bank_count = ROM_BANKS_RESET;
            foreach (bp_table[i]) bp_table[i] = '0;
        end else begin
            if (cfg_wr_en) rom_bank_count = cfg_wr_data;
            if (s_valid && s_ready) expected_results.push_back(predict_result(s_item));
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display("[%0t] result with none expected: status %0d hit_id %h",
                                 $realtime, m_item.status, m_item.hit_id);
                    end
                end else begin
                    want = expected_results.pop_front();
                    if (m_item.status !== want.status || m_item.hit_id !== want.hit_id) begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS) begin
                            $display("[%0t] mismatch: expected status %0d hit_id %h, got status %0d hit_id %h",
                                     $realtime, want.status, want.hit_id,
                                     m_item.status, m_item.hit_id);
                        end
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("banked_breakpoint_table verification failed");
            $finish;
        end
    end

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    function automatic in_item_t random_fields();
        logic [127:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom};
        return raw[$bits(in_item_t)-1:0];
    endfunction

    function automatic logic [31:0] random_id();
        int roll;
        roll = $urandom_range(19);
        if (roll == 0) return '0;
        if (roll < 3) return $urandom;
        return $urandom_range(ID_POOL, 1);
    endfunction

    function automatic int pick_live_entry();
        int live [$];
        foreach (bp_table[i]) begin
            if (bp_table[i].id != '0) live.push_back(i);
        end
        return (live.size() == 0) ? -1 : live[$urandom_range(live.size() - 1)];
    endfunction

    function automatic in_item_t make_set(logic [31:0] id, logic region, logic [8:0] bank,
                                          int start, int length, logic enable);
        in_item_t it;
        it = random_fields();
        it.operation    = OP_SET;
        it.point_id     = id;
        it.region       = region;
        it.bank         = bank;
        it.start_offset = 16'(start);
        it.span_length  = 17'(length);
        it.enable       = enable;
        return it;
    endfunction

    function automatic in_item_t make_remove(logic [31:0] id);
        in_item_t it;
        it = random_fields();
        it.operation = OP_REMOVE;
        it.point_id  = id;
        return it;
    endfunction

    function automatic in_item_t make_check(logic [15:0] pc, logic [8:0] low_bank,
                                            logic [8:0] high_bank, logic halted, logic irq);
        in_item_t it;
        it = random_fields();
        it.operation       = OP_CHECK;
        it.program_counter = pc;
        it.low_rom_bank    = low_bank;
        it.high_rom_bank   = high_bank;
        it.cpu_halted      = halted;
        it.irq_pending     = irq;
        return it;
    endfunction

    function automatic in_item_t random_item();
        in_item_t it;
        int roll;
        int span_limit;
        int start;
        int max_len;
        int bank_cap;
        int idx;
        int offset;
        it = random_fields();
        roll = $urandom_range(99);
        if (roll < 35) begin
            it.operation = OP_SET;
            it.point_id = random_id();
            if ($urandom_range(9) != 0) begin
                span_limit = it.region ? int'(BANK_SIZE) : int'(FLAT_SIZE);
                if (it.region) begin
                    bank_cap = (rom_bank_count > 512) ? 512 : int'(rom_bank_count);
                    if (bank_cap > 0) it.bank = 9'($urandom_range(bank_cap - 1));
                end else begin
                    it.bank = '0;
                end
                start = $urandom_range(span_limit - 1);
                max_len = span_limit - start;
                if ($urandom_range(3) != 0 && max_len > 512) max_len = 512;
                it.start_offset = 16'(start);
                it.span_length = 17'($urandom_range(max_len, 1));
            end
        end else if (roll < 50) begin
            it.operation = OP_REMOVE;
            idx = pick_live_entry();
            it.point_id = (idx >= 0 && $urandom_range(1) == 1) ? bp_table[idx].id : random_id();
        end else if (roll < 95) begin
            it.operation = OP_CHECK;
            it.cpu_halted = ($urandom_range(9) == 0);
            it.irq_pending = ($urandom_range(9) == 0);
            idx = pick_live_entry();
            if (idx >= 0 && $urandom_range(3) != 0) begin
                offset = int'(bp_table[idx].start)
                         + $urandom_range(int'(bp_table[idx].length) - 1);
                if (!bp_table[idx].region) begin
                    it.program_counter = 16'(offset);
                end else if ($urandom_range(1) == 1) begin
                    it.program_counter = 16'(offset);
                    it.low_rom_bank = bp_table[idx].bank;
                end else begin
                    it.program_counter = BANK_BASE + 16'(offset);
                    it.high_rom_bank = bp_table[idx].bank;
                end
            end
        end else begin
            it.operation = OP_NONE;
        end
        return it;
    endfunction

    task automatic send_item(in_item_t it);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= it;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic run_random(int count);
        repeat (count) send_item(random_item());
    endtask

    task automatic wait_results_drained();
        while (expected_results.size() != 0) @(negedge aclk);
    endtask

    task automatic write_rom_banks(logic [9:0] value);
        s_valid <= 1'b0;
        wait_results_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic test_directed();
        in_item_t idle_op;
        send_item(make_check(16'h0000, 9'd0, 9'd0, 1'b0, 1'b0));
        send_item(make_set(32'd0, 1'b0, 9'd0, 0, 1, 1'b1));
        send_item(make_set(32'd5, 1'b0, 9'd0, 0, 0, 1'b1));
        send_item(make_set(32'd5, 1'b0, 9'd1, 0, 1, 1'b1));
        send_item(make_set(32'hFFFF_FFFF, 1'b0, 9'd0, 0, 65536, 1'b1));
        send_item(make_check(16'hFFFF, 9'h1FF, 9'h1FF, 1'b0, 1'b0));
        send_item(make_check(16'h1234, 9'd0, 9'd0, 1'b1, 1'b0));
        send_item(make_check(16'h1234, 9'd0, 9'd0, 1'b0, 1'b1));
        send_item(make_set(32'd6, 1'b0, 9'd0, 65535, 2, 1'b1));
        send_item(make_set(32'd6, 1'b0, 9'd0, 65535, 1, 1'b1));
        send_item(make_set(32'd7, 1'b1, 9'd511, 16383, 1, 1'b1));
        send_item(make_set(32'd8, 1'b1, 9'd2, 16384, 1, 1'b1));
        send_item(make_set(32'd8, 1'b1, 9'd2, 12288, 4097, 1'b1));
        send_item(make_set(32'd9, 1'b1, 9'd3, 0, 16384, 1'b1));
        send_item(make_remove(32'hFFFF_FFFF));
        send_item(make_check(16'h7FFF, 9'd0, 9'd511, 1'b0, 1'b0));
        send_item(make_check(16'h3FFF, 9'd511, 9'd0, 1'b0, 1'b0));
        send_item(make_check(16'hBFFF, 9'd3, 9'd511, 1'b0, 1'b0));
        send_item(make_check(16'hFFFF, 9'd0, 9'd0, 1'b0, 1'b0));
        send_item(make_set(32'd7, 1'b0, 9'd0, 32768, 32768, 1'b0));
        send_item(make_check(16'h9000, 9'd0, 9'd0, 1'b0, 1'b0));
        send_item(make_check(16'h0100, 9'd3, 9'd0, 1'b0, 1'b0));
        send_item(make_remove(32'd0));
        send_item(make_remove(32'd12345));
        idle_op = random_fields();
        idle_op.operation = OP_NONE;
        send_item(idle_op);
    endtask

    task automatic test_rom_bank_limits();
        write_rom_banks(10'd2);
        run_random(150);
        write_rom_banks(10'd0);
        sender_idle_pct = 60;
        run_random(100);
        write_rom_banks(10'd1023);
        sender_idle_pct = 0;
        receiver_stall_pct = 60;
        run_random(100);
    endtask

    task automatic test_table_full();
        int          free_slots;
        logic [31:0] fill_ids [$];
        write_rom_banks(10'd512);
        sender_idle_pct = 16;
        receiver_stall_pct = 16;
        free_slots = 0;
        foreach (bp_table[i]) begin
            if (bp_table[i].id == '0) free_slots++;
        end
        for (int n = 0; n < free_slots + 4; n++) begin
            fill_ids.push_back(32'h8000_0000 + 32'(n));
            send_item(make_set(fill_ids[n], 1'b0, 9'd0, $urandom_range(65535), 1,
                               1'($urandom_range(1))));
        end
        send_item(make_set(fill_ids[0], 1'b0, 9'd0, 0, 65536, 1'b1));
        repeat (20) send_item(make_check(16'($urandom), 9'($urandom), 9'($urandom),
                                         1'b0, 1'b0));
        foreach (fill_ids[n]) send_item(make_remove(fill_ids[n]));
    endtask

    task automatic test_idling_mix();
        int sender_mix [4]   = '{0, 60, 0, 16};
        int receiver_mix [4] = '{0, 0, 60, 16};
        for (int phase = 0; phase < 4; phase++) begin
            write_rom_banks((phase == 3) ? 10'd512 : 10'($urandom_range(511, 2)));
            sender_idle_pct = sender_mix[phase];
            receiver_stall_pct = receiver_mix[phase];
            run_random(100);
        end
    endtask

    initial begin
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_rom_bank_limits();
        test_table_full();
        test_idling_mix();
        s_valid <= 1'b0;
        wait_results_drained();
        repeat (SETTLE_CYCLES) @(negedge aclk);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("banked_breakpoint_table verification clean");
        end else begin
            $display("banked_breakpoint_table verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
